// File: hw/rtl/tfsg_pkg.sv
`default_nettype none

package tfsg_pkg;

  // Flow table depth; must be a power of two no larger than the flow_id range.
  localparam int FLOW_ENTRIES = 1024;
  localparam int FLOW_AW      = $clog2(FLOW_ENTRIES);
  localparam int DIR_ENTRIES  = 2 * FLOW_ENTRIES;
  localparam int DIR_AW       = FLOW_AW + 1;
  localparam int CNT_W        = 32;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef enum logic [1:0] {
    EV_IN_ORDER = 2'd0,
    EV_MISS     = 2'd1,
    EV_RESEND   = 2'd2
  } seq_event_t;

  typedef enum logic {
    REG_PREFIX     = 1'b0,
    REG_PREFIX_LEN = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] mask;
  } cfg_t;

  // One row per flow and direction.
  typedef struct packed {
    logic             known;
    logic [31:0]      exp_seq;
    logic [CNT_W-1:0] pkts;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] resends;
  } dir_row_t;

  typedef struct packed {
    logic [FLOW_AW-1:0] flow;
    logic               to_client;
    logic [31:0]        seq;
    logic               syn;
    logic               fin;
    logic [15:0]        tot_len;
    logic [6:0]         hdr_sum;
  } item_t;

  typedef struct packed {
    logic             to_client;
    seq_event_t       seq_event;
    logic [31:0]      next_expected;
    logic [15:0]      payload_len;
    logic [CNT_W-1:0] flow_packets;
    logic [CNT_W-1:0] dir_packets;
    logic [CNT_W-1:0] dir_misses;
    logic [CNT_W-1:0] dir_resends;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tfsg_ram.sv
`default_nettype none

module tfsg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tfsg_cfg.sv
`default_nettype none

module tfsg_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output tfsg_pkg::cfg_t cfg
);

  import tfsg_pkg::*;

  logic [31:0] prefix;
  logic [5:0]  prefix_len;
  logic [5:0]  len_clamped;
  reg_idx_t    idx;
  logic        wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix     <= '0;
      prefix_len <= 6'd32;
    end else if (wr) begin
      unique case (idx)
        REG_PREFIX:     prefix     <= pwdata;
        REG_PREFIX_LEN: prefix_len <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PREFIX:     prdata = prefix;
      REG_PREFIX_LEN: prdata = {26'd0, prefix_len};
      default:        prdata = '0;
    endcase
  end

  // lengths above 32 act as 32; zero length gives an empty mask
  assign len_clamped = (prefix_len > 6'd32) ? 6'd32 : prefix_len;
  assign cfg.mask    = ~(32'hFFFF_FFFF >> len_clamped);
  assign cfg.prefix  = prefix;

endmodule

`default_nettype wire

// File: hw/rtl/tfsg_update.sv
`default_nettype none

module tfsg_update (
  input  tfsg_pkg::item_t                item,
  input  tfsg_pkg::dir_row_t             row,
  input  logic [tfsg_pkg::CNT_W-1:0]     flow_pkts,
  output tfsg_pkg::dir_row_t             row_next,
  output logic [tfsg_pkg::CNT_W-1:0]     flow_pkts_next,
  output tfsg_pkg::result_t              res
);

  import tfsg_pkg::*;

  logic [15:0] hdrs;
  logic [15:0] payload;
  logic [31:0] next_seq;
  seq_event_t  ev;

  assign hdrs = {9'd0, item.hdr_sum};

  always_comb begin
    if (item.syn || item.fin) begin
      payload  = '0;
      next_seq = item.seq + 32'd1;
    end else begin
      payload  = (item.tot_len > hdrs) ? item.tot_len - hdrs : 16'd0;
      next_seq = item.seq + {16'd0, payload};
    end
  end

  // plain unsigned compare, no sequence wrap handling
  always_comb begin
    ev = EV_IN_ORDER;
    if (row.known) begin
      if (row.exp_seq < item.seq) begin
        ev = EV_MISS;
      end else if (row.exp_seq > item.seq) begin
        ev = EV_RESEND;
      end
    end
  end

  always_comb begin
    row_next.known   = 1'b1;
    row_next.exp_seq = next_seq;
    row_next.pkts    = sat_inc(row.pkts);
    row_next.misses  = (ev == EV_MISS)   ? sat_inc(row.misses)  : row.misses;
    row_next.resends = (ev == EV_RESEND) ? sat_inc(row.resends) : row.resends;
  end

  assign flow_pkts_next = sat_inc(flow_pkts);

  always_comb begin
    res.to_client     = item.to_client;
    res.seq_event     = ev;
    res.next_expected = next_seq;
    res.payload_len   = payload;
    res.flow_packets  = flow_pkts_next;
    res.dir_packets   = row_next.pkts;
    res.dir_misses    = row_next.misses;
    res.dir_resends   = row_next.resends;
  end

endmodule

`default_nettype wire

// File: hw/rtl/tcp_flow_seq_gap_monitor_unit.sv
`default_nettype none

// Flow: a request is accepted into the capture register while the flow table is read;
//   the update and write back then load the output register, later while an older result waits.
// Requests are taken one at a time, accept then update, and the next is accepted only
//   after the write-back edge.
// Reset: synchronous, active high; then a clearing pass zeroes every direction
//   row and flow counter with in_ready low. Config writes are taken at any time.
module tcp_flow_seq_gap_monitor_unit (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  flow_id,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [31:0] seq_num,
  input  logic        syn_flag,
  input  logic        fin_flag,
  input  logic [15:0] ip_total_len,
  input  logic [5:0]  ip_hdr_len,
  input  logic [5:0]  tcp_hdr_len,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        to_client,
  output logic [1:0]  seq_event,
  output logic [31:0] next_expected,
  output logic [15:0] payload_len,
  output logic [31:0] flow_packets,
  output logic [31:0] dir_packets,
  output logic [31:0] dir_misses,
  output logic [31:0] dir_resends,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import tfsg_pkg::*;

  // ---------------------------------------------------------------
  // Signals
  // ---------------------------------------------------------------
  cfg_t               cfg;
  state_t             state;
  state_t             state_next;
  logic [DIR_AW-1:0]  clr_cnt;
  logic               clr_we;
  logic               upd_go;
  logic               accept;
  logic               slot_free;
  logic               to_client_in;
  item_t              item;
  dir_row_t           row_rd;
  dir_row_t           row_wr;
  dir_row_t           row_new;
  logic [CNT_W-1:0]   flow_rd;
  logic [CNT_W-1:0]   flow_wr;
  logic [CNT_W-1:0]   flow_new;
  logic [DIR_AW-1:0]  dir_waddr;
  logic [FLOW_AW-1:0] flow_waddr;
  result_t            res;
  result_t            res_q;

  // ---------------------------------------------------------------
  // Config registers and prefix mask
  // ---------------------------------------------------------------
  tfsg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Direction is resolved at accept time so the table read can use it as an
  // address bit. dst_addr does not take part in the decision.
  assign to_client_in = (src_addr & cfg.mask) == (cfg.prefix & cfg.mask);

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // ---------------------------------------------------------------
  // Control FSM
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clr_we) begin
        clr_cnt <= clr_cnt + {{(DIR_AW-1){1'b0}}, 1'b1};
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_cnt == {DIR_AW{1'b1}}) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_UPDATE;
      ST_UPDATE: if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // update waits in place while the output register is still full; the read
  // data registers hold since no new read is issued
  always_comb begin
    in_ready = 1'b0;
    clr_we   = 1'b0;
    upd_go   = 1'b0;
    unique case (state)
      ST_CLEAR:  clr_we   = 1'b1;
      ST_IDLE:   in_ready = 1'b1;
      ST_UPDATE: upd_go   = slot_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------
  // Request capture
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      item.flow      <= flow_id[FLOW_AW-1:0];
      item.to_client <= to_client_in;
      item.seq       <= seq_num;
      item.syn       <= syn_flag;
      item.fin       <= fin_flag;
      item.tot_len   <= ip_total_len;
      item.hdr_sum   <= {1'b0, ip_hdr_len} + {1'b0, tcp_hdr_len};
    end
  end

  // ---------------------------------------------------------------
  // Flow tables: per-direction rows and per-flow packet counters.
  // Read on accept, written back on update; one request in flight so no
  // read/write overlap on the same row.
  // ---------------------------------------------------------------
  assign dir_waddr  = clr_we ? clr_cnt : {item.flow, item.to_client};
  assign flow_waddr = clr_we ? clr_cnt[DIR_AW-1:1] : item.flow;
  assign row_wr     = clr_we ? '0 : row_new;
  assign flow_wr    = clr_we ? '0 : flow_new;

  tfsg_ram #(
    .WIDTH ($bits(dir_row_t)),
    .DEPTH (DIR_ENTRIES)
  ) u_dir_ram (
    .clk   (clk),
    .we    (clr_we || upd_go),
    .waddr (dir_waddr),
    .wdata (row_wr),
    .re    (accept),
    .raddr ({flow_id[FLOW_AW-1:0], to_client_in}),
    .rdata (row_rd)
  );

  tfsg_ram #(
    .WIDTH (CNT_W),
    .DEPTH (FLOW_ENTRIES)
  ) u_flow_ram (
    .clk   (clk),
    .we    (clr_we || upd_go),
    .waddr (flow_waddr),
    .wdata (flow_wr),
    .re    (accept),
    .raddr (flow_id[FLOW_AW-1:0]),
    .rdata (flow_rd)
  );

  // ---------------------------------------------------------------
  // Sequence check and counter update
  // ---------------------------------------------------------------
  tfsg_update u_update (
    .item           (item),
    .row            (row_rd),
    .flow_pkts      (flow_rd),
    .row_next       (row_new),
    .flow_pkts_next (flow_new),
    .res            (res)
  );

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      res_q <= res;
    end
  end

  assign to_client     = res_q.to_client;
  assign seq_event     = res_q.seq_event;
  assign next_expected = res_q.next_expected;
  assign payload_len   = res_q.payload_len;
  assign flow_packets  = res_q.flow_packets;
  assign dir_packets   = res_q.dir_packets;
  assign dir_misses    = res_q.dir_misses;
  assign dir_resends   = res_q.dir_resends;

endmodule

`default_nettype wire

// File: hw/rtl/tfsg_checker.sv
`default_nettype none

module tfsg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  seq_event,
  input logic [31:0] next_expected,
  input logic [31:0] flow_packets,
  input logic [31:0] dir_packets,
  input logic [31:0] dir_misses,
  input logic [31:0] dir_resends
);

  import tfsg_pkg::*;

  // one request at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while one is in flight");

  // once the update edge has passed, a result is on offer: the new one, or an
  // older one still waiting on out_ready
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> ##2 out_valid)
    else $error("result missing after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(next_expected)))
    else $error("stalled result dropped or changed");

  a_dir_le_flow: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (dir_packets <= flow_packets))
    else $error("direction count above flow count");

  a_events_le_pkts: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (({1'b0, dir_misses} + {1'b0, dir_resends} <= {1'b0, dir_packets})
                   && (seq_event != 2'd3)))
    else $error("event counters inconsistent");

endmodule

bind tcp_flow_seq_gap_monitor_unit tfsg_checker u_tfsg_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .seq_event     (seq_event),
  .next_expected (next_expected),
  .flow_packets  (flow_packets),
  .dir_packets   (dir_packets),
  .dir_misses    (dir_misses),
  .dir_resends   (dir_resends)
);

`default_nettype wire

// File: test/tb_tcp_flow_seq_gap_monitor_unit.sv
`timescale 1ns / 100ps

module tb_tcp_flow_seq_gap_monitor_unit;
  import tfsg_pkg::*;

  // Watchdog limit; a normal run includes the table clear after reset.
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned IDLE_PCT    = 12;
  localparam int unsigned PHASE_REQS  = 64;

  // One parsed header as driven onto the request channel.
  typedef struct packed {
    logic [9:0]  flow_id;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] seq_num;
    logic        syn_flag;
    logic        fin_flag;
    logic [15:0] ip_total_len;
    logic [5:0]  ip_hdr_len;
    logic [5:0]  tcp_hdr_len;
  } hdr_req_t;

  // Scoreboard: mirrors the flow table, predicts one report per header
  // and compares reports in order.
  class seq_gap_scoreboard;
    bit [31:0]   prefix;
    bit [5:0]    prefix_len;
    bit [31:0]   next_seq    [2][FLOW_ENTRIES];
    bit          seq_known   [2][FLOW_ENTRIES];
    bit [31:0]   flow_pkts   [FLOW_ENTRIES];
    bit [31:0]   dir_pkts    [2][FLOW_ENTRIES];
    bit [31:0]   dir_gaps    [2][FLOW_ENTRIES];
    bit [31:0]   dir_resends [2][FLOW_ENTRIES];
    result_t     pending_reports[$];
    int unsigned errors;

    function new();
      prefix     = '0;
      prefix_len = 6'd32;
      errors     = 0;
    endfunction

    function bit [31:0] bump(bit [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // lengths past 32 behave as 32; zero matches everything
    function bit [31:0] server_mask();
      bit [5:0] len;
      len = (prefix_len > 6'd32) ? 6'd32 : prefix_len;
      return (len == 6'd0) ? 32'h0 : (32'hFFFF_FFFF << (6'd32 - len));
    endfunction

    function bit is_server(bit [31:0] addr);
      bit [31:0] m;
      m = server_mask();
      return (addr & m) == (prefix & m);
    endfunction

    function void note_header(hdr_req_t h);
      bit          d;
      int unsigned f;
      bit [6:0]    hdrs;
      bit [15:0]   pay;
      bit [31:0]   nxt;
      result_t     e;
      f = h.flow_id % FLOW_ENTRIES;
      d = is_server(h.src_addr);
      flow_pkts[f]   = bump(flow_pkts[f]);
      dir_pkts[d][f] = bump(dir_pkts[d][f]);
      e.seq_event = EV_IN_ORDER;
      if (seq_known[d][f]) begin
        // plain unsigned compare, no wrap handling
        if (next_seq[d][f] < h.seq_num) begin
          e.seq_event    = EV_MISS;
          dir_gaps[d][f] = bump(dir_gaps[d][f]);
        end else if (next_seq[d][f] > h.seq_num) begin
          e.seq_event       = EV_RESEND;
          dir_resends[d][f] = bump(dir_resends[d][f]);
        end
      end
      hdrs = {1'b0, h.ip_hdr_len} + {1'b0, h.tcp_hdr_len};
      pay  = '0;
      if (h.syn_flag || h.fin_flag) begin
        nxt = h.seq_num + 32'd1;
      end else begin
        if (h.ip_total_len > {9'b0, hdrs}) pay = h.ip_total_len - {9'b0, hdrs};
        nxt = h.seq_num + {16'b0, pay};
      end
      next_seq[d][f]  = nxt;
      seq_known[d][f] = 1'b1;
      e.to_client     = d;
      e.next_expected = nxt;
      e.payload_len   = pay;
      e.flow_packets  = flow_pkts[f];
      e.dir_packets   = dir_pkts[d][f];
      e.dir_misses    = dir_gaps[d][f];
      e.dir_resends   = dir_resends[d][f];
      pending_reports.push_back(e);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0h, got %0h", field, want, seen);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (pending_reports.size() == 0) begin
        $error("report with no request outstanding");
        errors++;
        return;
      end
      e = pending_reports.pop_front();
      compare("to_client", 32'(e.to_client), 32'(got.to_client));
      compare("seq_event", 32'(e.seq_event), 32'(got.seq_event));
      compare("next_expected", e.next_expected, got.next_expected);
      compare("payload_len", 32'(e.payload_len), 32'(got.payload_len));
      compare("flow_packets", e.flow_packets, got.flow_packets);
      compare("dir_packets", e.dir_packets, got.dir_packets);
      compare("dir_misses", e.dir_misses, got.dir_misses);
      compare("dir_resends", e.dir_resends, got.dir_resends);
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [9:0]  flow_id = '0;
  logic [31:0] src_addr = '0;
  logic [31:0] dst_addr = '0;
  logic [31:0] seq_num = '0;
  logic        syn_flag = 1'b0;
  logic        fin_flag = 1'b0;
  logic [15:0] ip_total_len = '0;
  logic [5:0]  ip_hdr_len = 6'd20;
  logic [5:0]  tcp_hdr_len = 6'd20;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        to_client;
  logic [1:0]  seq_event;
  logic [31:0] next_expected;
  logic [15:0] payload_len;
  logic [31:0] flow_packets;
  logic [31:0] dir_packets;
  logic [31:0] dir_misses;
  logic [31:0] dir_resends;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // steady: both sides run without idling while set
  logic        steady = 1'b0;
  int unsigned cycles = 0;

  seq_gap_scoreboard sb = new();

  tcp_flow_seq_gap_monitor_unit u_top (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // Receiver: random backpressure, ~12% of cycles, none while steady.
  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Report monitor: values sampled at the edge, before any update from it.
  always @(posedge clk) begin : report_mon
    result_t seen;
    if (!rst && out_valid && out_ready) begin
      seen.to_client     = to_client;
      seen.seq_event     = seq_event_t'(seq_event);
      seen.next_expected = next_expected;
      seen.payload_len   = payload_len;
      seen.flow_packets  = flow_packets;
      seen.dir_packets   = dir_packets;
      seen.dir_misses    = dir_misses;
      seen.dir_resends   = dir_resends;
      sb.check_result(seen);
    end
  end

  // Drives one request and returns at the edge where it is taken.
  // in_valid stays high afterwards; the next request, a gap or a drain
  // lowers or reuses it, so it never gets two updates in one step.
  task automatic send_hdr(input hdr_req_t h);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    flow_id      <= h.flow_id;
    src_addr     <= h.src_addr;
    dst_addr     <= h.dst_addr;
    seq_num      <= h.seq_num;
    syn_flag     <= h.syn_flag;
    fin_flag     <= h.fin_flag;
    ip_total_len <= h.ip_total_len;
    ip_hdr_len   <= h.ip_hdr_len;
    tcp_hdr_len  <= h.tcp_hdr_len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_header(h);
  endtask

  // Stop sending and wait for every outstanding report, then let the
  // pipeline settle before touching the registers.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup then access phase; psel stays up across back-to-back writes.
  task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [31:0] pfx, input logic [5:0] plen);
    apb_write(REG_PREFIX, pfx);
    apb_write(REG_PREFIX_LEN, {26'b0, plen});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.prefix     = pfx;
    sb.prefix_len = plen;
  endtask

  function automatic hdr_req_t hdr(input logic [9:0] f, input logic [31:0] src,
                                   input logic [31:0] seq, input logic syn,
                                   input logic fin, input logic [15:0] tot,
                                   input logic [5:0] ihl, input logic [5:0] thl);
    hdr_req_t h;
    h = '{f, src, $urandom, seq, syn, fin, tot, ihl, thl};
    return h;
  endfunction

  // Random header. Most traffic hits a dozen hot flows and follows the
  // predicted sequence so the table sees long in-order runs, with gaps,
  // resends, handshakes and odd lengths mixed in.
  function automatic hdr_req_t random_hdr();
    hdr_req_t    h;
    bit [31:0]   m;
    bit          d;
    int unsigned pick;
    int unsigned f;
    bit [6:0]    hdrs;
    m = sb.server_mask();
    if ($urandom_range(0, 99) < 80) begin
      pick      = $urandom_range(0, 11);
      h.flow_id = (pick < 6) ? 10'(pick) : 10'(1023 - (pick - 6));
    end else begin
      h.flow_id = 10'($urandom_range(0, 1023));
    end
    h.src_addr = $urandom_range(0, 1) ? ((sb.prefix & m) | ($urandom & ~m)) : $urandom;
    h.dst_addr = $urandom;
    d = sb.is_server(h.src_addr);
    f = h.flow_id;
    h.syn_flag = ($urandom_range(0, 99) < (sb.seq_known[d][f] ? 6 : 40));
    h.fin_flag = ($urandom_range(0, 99) < 6);
    pick = $urandom_range(0, 99);
    if (!sb.seq_known[d][f] || pick >= 92) h.seq_num = $urandom;
    else if (pick < 64) h.seq_num = sb.next_seq[d][f];
    else if (pick < 78) h.seq_num = sb.next_seq[d][f] + $urandom_range(1, 3000);
    else h.seq_num = sb.next_seq[d][f] - $urandom_range(1, 3000);
    h.ip_hdr_len  = ($urandom_range(0, 99) < 70) ? 6'd20 : 6'($urandom_range(20, 60));
    h.tcp_hdr_len = 6'($urandom_range(20, 60));
    hdrs = {1'b0, h.ip_hdr_len} + {1'b0, h.tcp_hdr_len};
    pick = $urandom_range(0, 99);
    if (pick < 70) h.ip_total_len = 16'(hdrs + $urandom_range(0, 1460));
    else if (pick < 85) h.ip_total_len = 16'($urandom_range(0, 65535));
    else h.ip_total_len = 16'($urandom_range(0, hdrs));  // underflow or empty
    return h;
  endfunction

  task automatic run_phase(input logic [31:0] pfx, input logic [5:0] plen,
                           input bit calm);
    drain();
    write_cfg(pfx, plen);
    steady <= calm;
    repeat (PHASE_REQS) send_hdr(random_hdr());
    steady <= 1'b0;
  endtask

  localparam logic [31:0] CLI = 32'h0A01_0203;
  localparam logic [31:0] SRV = 32'hC0A8_01FE;

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Server side is a /24; the table clear runs meanwhile and holds off
    // requests via in_ready.
    write_cfg(32'hC0A8_0100, 6'd24);

    // first packet in each direction, SYN wrapping the expected value to 0
    send_hdr(hdr(10'd0, CLI, 32'd1000, 1'b1, 1'b0, 16'd40, 6'd20, 6'd20));
    send_hdr(hdr(10'd0, SRV, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'd44, 6'd24, 6'd20));
    // in order with the largest total length
    send_hdr(hdr(10'd0, CLI, sb.next_seq[0][0], 1'b0, 1'b0, 16'hFFFF, 6'd20, 6'd20));
    // gap, with headers longer than the packet
    send_hdr(hdr(10'd0, CLI, sb.next_seq[0][0] + 32'd100, 1'b0, 1'b0, 16'd60, 6'd60,
                 6'd60));
    // resend carrying FIN
    send_hdr(hdr(10'd0, CLI, sb.next_seq[0][0] - 32'd50, 1'b0, 1'b1, 16'd52, 6'd20,
                 6'd32));
    send_hdr(hdr(10'd0, SRV, 32'd0, 1'b0, 1'b0, 16'd0, 6'd60, 6'd60));
    // payload exactly zero, then repeat of the same sequence
    send_hdr(hdr(10'd1023, CLI, 32'd0, 1'b0, 1'b0, 16'd40, 6'd20, 6'd20));
    send_hdr(hdr(10'd1023, CLI, 32'd0, 1'b0, 1'b0, 16'd40, 6'd20, 6'd20));
    // top of the sequence space: expected value wraps past zero
    send_hdr(hdr(10'd1023, CLI, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'd1500, 6'd20, 6'd20));
    send_hdr(hdr(10'd1023, CLI, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'd40, 6'd20, 6'd20));
    // all-ones and all-zeros fields
    send_hdr('{10'd1023, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF,
               6'd60, 6'd60});
    send_hdr('{10'd0, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 16'h0, 6'd20, 6'd20});
    // alternating bit patterns
    send_hdr(hdr(10'h2AA, SRV, 32'h5555_5555, 1'b0, 1'b0, 16'h5555, 6'd21, 6'd42));
    send_hdr(hdr(10'h155, CLI, 32'hAAAA_AAAA, 1'b0, 1'b0, 16'hAAAA, 6'd42, 6'd21));

    // zero-length prefix: every source counts as the server
    drain();
    write_cfg(32'hFFFF_FFFF, 6'd0);
    send_hdr(hdr(10'd0, 32'h0, sb.next_seq[1][0], 1'b0, 1'b0, 16'd140, 6'd20, 6'd20));
    send_hdr(hdr(10'd5, 32'h1234_5678, 32'd7, 1'b0, 1'b0, 16'd100, 6'd20, 6'd20));

    // prefix length past 32 acts as an exact host match
    drain();
    write_cfg(32'hC0A8_0105, 6'd63);
    send_hdr(hdr(10'd0, 32'hC0A8_0105, 32'd10, 1'b0, 1'b0, 16'd50, 6'd20, 6'd20));
    send_hdr(hdr(10'd0, 32'hC0A8_0104, 32'd10, 1'b0, 1'b0, 16'd50, 6'd20, 6'd20));

    // full 32-bit match; top address bit alone differs
    drain();
    write_cfg(32'hC0A8_0105, 6'd32);
    send_hdr(hdr(10'd0, 32'hC0A8_0105, sb.next_seq[1][0], 1'b0, 1'b0, 16'd50, 6'd20,
                 6'd20));
    send_hdr(hdr(10'd0, 32'h40A8_0105, 32'd9, 1'b0, 1'b0, 16'd50, 6'd20, 6'd20));

    // Random traffic under a spread of prefix settings. Each phase starts
    // only after every report is in, so the sender also fully pauses.
    run_phase($urandom, 6'd24, 1'b0);
    run_phase(32'hFFFF_FFFF, 6'd32, 1'b0);
    run_phase(32'h0, 6'd0, 1'b1);            // long stretch without idling
    run_phase($urandom, 6'd8, 1'b0);
    run_phase($urandom, 6'd16, 1'b0);
    run_phase($urandom, 6'($urandom_range(1, 31)), 1'b0);
    run_phase(32'h0, 6'd32, 1'b0);           // back to reset values

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

endmodule

// File: tcp_flow_seq_gap_monitor_unit.f
hw/rtl/tfsg_pkg.sv
hw/rtl/tfsg_ram.sv
hw/rtl/tfsg_cfg.sv
hw/rtl/tfsg_update.sv
hw/rtl/tcp_flow_seq_gap_monitor_unit.sv
hw/rtl/tfsg_checker.sv
test/tb_tcp_flow_seq_gap_monitor_unit.sv
